[hw/rtl/pbfp_pkg.sv]
// Package for the parallel-beam forward projector core.
// Holds default sizes, field widths, the action codes and the Q1.15 sine ROM.
// No dependencies.
package pbfp_pkg;

    localparam int IMAGE_WIDTH_DEF  = 512;
    localparam int IMAGE_HEIGHT_DEF = 512;
    localparam int ANGLE_COUNT_DEF  = 360;

    localparam int IDX_W    = 9;   // angle, row, column and bin fields
    localparam int PIXEL_W  = 16;
    localparam int SUM_W    = 32;
    localparam int TRIG_W   = 16;
    localparam int S_DATA_W = 56;  // 52 payload bits padded to bytes
    localparam int M_DATA_W = 48;  // 41 payload bits padded to bytes

    localparam logic ACT_ACCUMULATE = 1'b0;
    localparam logic ACT_READ       = 1'b1;

    // First quadrant of round(32768*sin(d)), d = 0..90, top entry held at 32767.
    localparam logic [TRIG_W-1:0] QUARTER_SINE [91] = '{
        16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
        16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
        16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
        16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
        16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
        16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
        16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
        16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
        16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
        16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
        16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
        16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
        16'd28378, 16'd28660, 16'd28932, 16'd29196, 16'd29452,
        16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
        16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
        16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
        16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
        16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
        16'd32767
    };

    // Sine in Q1.15 of an angle in degrees below 720, reduced modulo 360.
    function automatic logic signed [TRIG_W-1:0] sine_q15(input logic [9:0] deg);
        logic [8:0]        d;
        logic [6:0]        r;
        logic              neg;
        logic [TRIG_W-1:0] mag;
        d = (deg >= 10'd360) ? 9'(deg - 10'd360) : 9'(deg);
        if (d < 9'd90) begin
            r   = d[6:0];
            neg = 1'b0;
        end else if (d < 9'd180) begin
            r   = 7'(9'd180 - d);
            neg = 1'b0;
        end else if (d < 9'd270) begin
            r   = 7'(d - 9'd180);
            neg = 1'b1;
        end else begin
            r   = 7'(9'd360 - d);
            neg = 1'b1;
        end
        mag = QUARTER_SINE[r];
        return neg ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

[hw/rtl/parallel_beam_forward_projector_core.sv]
// Pixel-driven parallel-beam forward projector with nearest-bin assignment.
// Transactions are taken one at a time through the steps accept, table lookup, multiply,
// bin and read, and read-modify-write of the sinogram RAM; s_axis_tready is high only
// while idle, and write-back stalls while the output holds a result not yet taken.
// Reset (synchronous, active low) clears control state, then a clearing pass zeroes all
// ANGLE_COUNT * 2^ceil(log2(IMAGE_WIDTH)) words (184320 by default), s_axis_tready low.
module parallel_beam_forward_projector_core #(
    parameter int IMAGE_WIDTH  = pbfp_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = pbfp_pkg::IMAGE_HEIGHT_DEF,
    parameter int ANGLE_COUNT  = pbfp_pkg::ANGLE_COUNT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // angle_index[8:0], pixel_row[17:9], pixel_column[26:18], pixel_value[42:27],
    // read_bin[51:43], zero pad above
    input  logic [pbfp_pkg::S_DATA_W-1:0] s_axis_tdata,
    // action
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // bin_value[31:0], hit_bin[40:32], zero pad above
    output logic [pbfp_pkg::M_DATA_W-1:0] m_axis_tdata,
    // hit_valid
    output logic                          m_axis_tuser
);
    import pbfp_pkg::*;

    localparam int BIN_W     = $clog2(IMAGE_WIDTH);
    localparam int DIM_MAX   = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int DIM_W     = $clog2(DIM_MAX);
    localparam int COORD_W   = ((DIM_W > IDX_W + 1) ? DIM_W : IDX_W + 1) + 2;
    localparam int PROD_W    = COORD_W + TRIG_W;
    localparam int ACC_W     = COORD_W + 18;
    localparam int MEM_DEPTH = ANGLE_COUNT * (1 << BIN_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    localparam logic signed [ACC_W-1:0] ACC_OFFSET = ACC_W'((IMAGE_WIDTH / 2) * 65536);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TRIG = 5'b00010,
        S_MUL  = 5'b00100,
        S_ADDR = 5'b01000,
        S_WB   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic               r_action;
    logic [IDX_W-1:0]   r_angle, r_row, r_col, r_rbin;
    logic [PIXEL_W-1:0] r_value;

    logic signed [TRIG_W-1:0]  r_cos, r_sin;
    logic signed [COORD_W-1:0] r_xh, r_yh;
    logic signed [PROD_W-1:0]  r_pc, r_ps;

    logic              r_ok;
    logic [BIN_W-1:0]  r_bin;
    logic [ADDR_W-1:0] r_addr;
    logic [SUM_W-1:0]  r_rd_data;

    logic              r_out_valid;
    logic [SUM_W-1:0]  r_out_value;
    logic [IDX_W-1:0]  r_out_bin;
    logic              r_out_hit;

    logic [SUM_W-1:0]  mem [MEM_DEPTH];

    logic                     in_fire;
    logic                     out_free;
    logic                     wb_fire;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-17:0]        acc_hi;
    logic                     angle_ok, pix_ok, bin_ok, rbin_ok, n_ok;
    logic [BIN_W-1:0]         n_bin;
    logic [ADDR_W-1:0]        n_addr;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_sat;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [SUM_W-1:0]         mem_wdata;
    logic                     mem_re;

    assign s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign wb_fire       = (r_state == S_WB) && out_free;

    // Bin from the rotated coordinate, floor(acc / 2^16) by arithmetic shift, or read_bin for a read.
    always_comb begin
        acc      = ACC_W'(r_pc) + ACC_W'(r_ps) + ACC_OFFSET;
        acc_hi   = acc[ACC_W-1:16];
        angle_ok = 32'(r_angle) < 32'(ANGLE_COUNT);
        pix_ok   = (32'(r_row) < 32'(IMAGE_HEIGHT)) && (32'(r_col) < 32'(IMAGE_WIDTH));
        bin_ok   = !acc[ACC_W-1] && (acc_hi < (ACC_W-16)'(IMAGE_WIDTH));
        rbin_ok  = 32'(r_rbin) < 32'(IMAGE_WIDTH);
        if (r_action == ACT_READ) begin
            n_ok  = angle_ok && rbin_ok;
            n_bin = BIN_W'(r_rbin);
        end else begin
            n_ok  = angle_ok && pix_ok && bin_ok;
            n_bin = BIN_W'(acc_hi);
        end
        n_addr = ADDR_W'({r_angle, n_bin});
    end

    always_comb begin
        sum_wide = {1'b0, r_rd_data} + (SUM_W + 1)'(r_value);
        sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_fire) n_state = S_TRIG;
            S_TRIG:  n_state = S_MUL;
            S_MUL:   n_state = S_ADDR;
            S_ADDR:  n_state = S_WB;
            S_WB:    if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath registers; each stage is loaded only in its own state.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= s_axis_tuser;
            r_angle  <= s_axis_tdata[8:0];
            r_row    <= s_axis_tdata[17:9];
            r_col    <= s_axis_tdata[26:18];
            r_value  <= s_axis_tdata[42:27];
            r_rbin   <= s_axis_tdata[51:43];
        end
        if (r_state == S_TRIG) begin
            r_sin <= sine_q15({1'b0, r_angle});
            r_cos <= sine_q15(10'(r_angle) + 10'd90);
            r_xh  <= $signed(COORD_W'({r_col, 1'b0})) - $signed(COORD_W'(IMAGE_WIDTH - 1));
            r_yh  <= $signed(COORD_W'(IMAGE_HEIGHT - 1)) - $signed(COORD_W'({r_row, 1'b0}));
        end
        if (r_state == S_MUL) begin
            r_pc <= r_xh * r_cos;
            r_ps <= r_yh * r_sin;
        end
        if (r_state == S_ADDR) begin
            r_ok   <= n_ok;
            r_bin  <= n_bin;
            r_addr <= n_addr;
        end
    end

    // Sinogram RAM: one write port shared with the clearing pass, one read port.
    assign mem_re    = (r_state == S_ADDR) && n_ok;
    assign mem_we    = r_clr_busy || (wb_fire && r_ok);
    assign mem_waddr = r_clr_busy ? r_clr_addr : r_addr;
    assign mem_wdata = (r_clr_busy || r_action == ACT_READ) ? '0 : sum_sat;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[n_addr];
        end
    end

    // Output register decouples the result from the next transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (wb_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire) begin
            if (!r_ok) begin
                r_out_value <= '0;
                r_out_bin   <= '0;
                r_out_hit   <= 1'b0;
            end else if (r_action == ACT_READ) begin
                r_out_value <= r_rd_data;
                r_out_bin   <= '0;
                r_out_hit   <= 1'b0;
            end else begin
                r_out_value <= sum_sat;
                r_out_bin   <= IDX_W'(r_bin);
                r_out_hit   <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_W'({r_out_bin, r_out_value});
    assign m_axis_tuser  = r_out_hit;

endmodule
